### src/assert_macros.svh
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a consequence in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a consequence in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/tswc_pkg.sv
// Types, constants and sequence-space helpers for the TCP segment window check
`default_nettype none

package tswc_pkg;

	localparam int unsigned SEQ_W  = 32;
	localparam int unsigned WND_W  = 31;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned SIGN_B = SEQ_W - 1;

	typedef logic [SEQ_W-1:0] seq_t;
	typedef logic [WND_W-1:0] wnd_t;
	typedef logic [LEN_W-1:0] len_t;

	typedef struct packed {
		seq_t rnxt;
		logic rwnd_zero;
		seq_t seq;
		logic len_zero;
		seq_t ack;
		seq_t una;
		seq_t snxt;
		seq_t wl1;
		seq_t wl2;
		seq_t iss;
		seq_t rend;
		seq_t rend_m1;
		seq_t send;
		seq_t send_m1;
		seq_t send_p1;
		seq_t seq_m1;
		seq_t sedge;
		seq_t sedge_p1;
		seq_t diff;
	} s1_t;

	typedef struct packed {
		logic acc;
		logic ready;
		logic tl_hit;
		seq_t tl_val;
		logic tr_hit;
		seq_t tr_val;
		logic nwu;
		logic ack_acc;
		logic dup;
		logic syn;
		logic fully;
	} s2_t;

	typedef struct packed {
		logic seg_acceptable;
		logic seg_ready;
		len_t trim_left;
		len_t trim_right;
		logic ack_acceptable;
		logic ack_duplicate;
		logic new_window_update;
		logic syn_acked;
		logic seg_fully_acked;
	} res_t;

	// a <= b < c on the circle
	function automatic logic in_le_lt(input seq_t a, input seq_t b, input seq_t c);
		if (a <= c) begin
			return (a <= b) && (b < c);
		end
		return (b < c) || (a <= b);
	endfunction

	// a < b <= c on the circle
	function automatic logic in_lt_le(input seq_t a, input seq_t b, input seq_t c);
		if (a <= c) begin
			return (a < b) && (b <= c);
		end
		return (b <= c) || (a < b);
	endfunction

	function automatic len_t sat16(input seq_t v);
		return (|v[SEQ_W-1:LEN_W]) ? {LEN_W{1'b1}} : v[LEN_W-1:0];
	endfunction

endpackage

`default_nettype wire

### src/tswc_seg_if.sv
// Segment input channel: valid, ready and the segment and connection fields
`default_nettype none

interface tswc_seg_if;
	logic              valid;
	logic              ready;
	tswc_pkg::seq_t    rcv_next;
	tswc_pkg::wnd_t    rcv_window;
	tswc_pkg::seq_t    snd_unacked;
	tswc_pkg::seq_t    snd_next;
	tswc_pkg::wnd_t    snd_window;
	tswc_pkg::seq_t    wnd_upd_seq;
	tswc_pkg::seq_t    wnd_upd_ack;
	tswc_pkg::seq_t    initial_send_seq;
	tswc_pkg::seq_t    seg_seq;
	tswc_pkg::len_t    seg_length;
	tswc_pkg::seq_t    seg_ack;

	modport source (
		output valid, rcv_next, rcv_window, snd_unacked, snd_next, snd_window,
		       wnd_upd_seq, wnd_upd_ack, initial_send_seq, seg_seq, seg_length, seg_ack,
		input  ready
	);
	modport sink (
		input  valid, rcv_next, rcv_window, snd_unacked, snd_next, snd_window,
		       wnd_upd_seq, wnd_upd_ack, initial_send_seq, seg_seq, seg_length, seg_ack,
		output ready
	);
endinterface

`default_nettype wire

### src/tswc_res_if.sv
// Result output channel: valid, ready and the check results
`default_nettype none

interface tswc_res_if;
	logic           valid;
	logic           ready;
	logic           seg_acceptable;
	logic           seg_ready;
	tswc_pkg::len_t trim_left;
	tswc_pkg::len_t trim_right;
	logic           ack_acceptable;
	logic           ack_duplicate;
	logic           new_window_update;
	logic           syn_acked;
	logic           seg_fully_acked;

	modport source (
		output valid, seg_acceptable, seg_ready, trim_left, trim_right, ack_acceptable,
		       ack_duplicate, new_window_update, syn_acked, seg_fully_acked,
		input  ready
	);
	modport sink (
		input  valid, seg_acceptable, seg_ready, trim_left, trim_right, ack_acceptable,
		       ack_duplicate, new_window_update, syn_acked, seg_fully_acked,
		output ready
	);
endinterface

`default_nettype wire

### src/tswc_sum.sv
// Stage 1: sequence sums and differences for the window tests
`default_nettype none

module tswc_sum (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	tswc_seg_if.sink           seg,
	output tswc_pkg::s1_t      data_s1,
	output logic               valid_s1
);
	tswc_pkg::seq_t rend;
	tswc_pkg::seq_t send;
	tswc_pkg::seq_t sedge;

	assign rend  = seg.rcv_next + {1'b0, seg.rcv_window};
	assign send  = seg.seg_seq + {{(tswc_pkg::SEQ_W-tswc_pkg::LEN_W){1'b0}}, seg.seg_length};
	assign sedge = seg.snd_unacked + {1'b0, seg.snd_window};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= seg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && seg.valid) begin
			data_s1.rnxt      <= seg.rcv_next;
			data_s1.rwnd_zero <= (seg.rcv_window == '0);
			data_s1.seq       <= seg.seg_seq;
			data_s1.len_zero  <= (seg.seg_length == '0);
			data_s1.ack       <= seg.seg_ack;
			data_s1.una       <= seg.snd_unacked;
			data_s1.snxt      <= seg.snd_next;
			data_s1.wl1       <= seg.wnd_upd_seq;
			data_s1.wl2       <= seg.wnd_upd_ack;
			data_s1.iss       <= seg.initial_send_seq;
			data_s1.rend      <= rend;
			data_s1.rend_m1   <= seg.rcv_next + {1'b0, seg.rcv_window} - 32'd1;
			data_s1.send      <= send;
			data_s1.send_m1   <= seg.seg_seq
				+ {{(tswc_pkg::SEQ_W-tswc_pkg::LEN_W){1'b0}}, seg.seg_length} - 32'd1;
			data_s1.send_p1   <= seg.seg_seq
				+ {{(tswc_pkg::SEQ_W-tswc_pkg::LEN_W){1'b0}}, seg.seg_length} + 32'd1;
			data_s1.seq_m1    <= seg.seg_seq - 32'd1;
			data_s1.sedge     <= sedge;
			data_s1.sedge_p1  <= seg.snd_unacked + {1'b0, seg.snd_window} + 32'd1;
			data_s1.diff      <= seg.seg_ack - seg.snd_unacked;
		end
	end
endmodule

`default_nettype wire

### src/tswc_cmp.sv
// Stage 2: circular interval compares and acceptability decision
`default_nettype none

module tswc_cmp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           valid_s1,
	input  tswc_pkg::s1_t       data_s1,
	output tswc_pkg::s2_t       data_s2,
	output logic                valid_s2
);
	tswc_pkg::s1_t d;
	logic a0, a1, a2, a3;
	logic acc;

	assign d  = data_s1;
	assign a0 = tswc_pkg::in_le_lt(d.rnxt, d.seq, d.rend);
	assign a1 = tswc_pkg::in_le_lt(d.rnxt, d.send_m1, d.rend);
	assign a2 = tswc_pkg::in_le_lt(d.seq, d.rnxt, d.send);
	assign a3 = tswc_pkg::in_le_lt(d.seq, d.rend_m1, d.send);

	always_comb begin
		priority if (d.len_zero && d.rwnd_zero) begin
			acc = (d.seq == d.rnxt);
		end else if (d.len_zero) begin
			acc = a0;
		end else if (d.rwnd_zero) begin
			acc = 1'b0;
		end else begin
			acc = a0 || a1 || a2 || a3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			data_s2.acc     <= acc;
			data_s2.ready   <= tswc_pkg::in_le_lt(d.seq, d.rnxt, d.send_p1);
			data_s2.tl_hit  <= tswc_pkg::in_lt_le(d.seq, d.rnxt, d.rend);
			data_s2.tl_val  <= d.rnxt - d.seq;
			data_s2.tr_hit  <= !tswc_pkg::in_lt_le(d.seq_m1, d.send, d.rend);
			data_s2.tr_val  <= d.send - d.rend;
			data_s2.nwu     <= tswc_pkg::in_lt_le(d.wl1, d.seq, d.sedge)
				|| ((d.wl1 == d.seq) && tswc_pkg::in_le_lt(d.wl2, d.ack, d.sedge_p1));
			data_s2.ack_acc <= tswc_pkg::in_lt_le(d.una, d.ack, d.snxt);
			data_s2.dup     <= (d.diff == '0) || d.diff[tswc_pkg::SIGN_B];
			data_s2.syn     <= tswc_pkg::in_lt_le(d.iss, d.una, d.snxt);
			data_s2.fully   <= !d.len_zero && tswc_pkg::in_lt_le(d.seq, d.send, d.una);
		end
	end
endmodule

`default_nettype wire

### src/tswc_out.sv
// Stage 3: gate by acceptability, saturate trims, hold the result register
`default_nettype none
`include "assert_macros.svh"

module tswc_out (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          valid_s2,
	input  tswc_pkg::s2_t      data_s2,
	output tswc_pkg::res_t     data_s3,
	output logic               valid_s3
);
	tswc_pkg::res_t r;

	always_comb begin
		r.seg_acceptable    = data_s2.acc;
		r.seg_ready         = data_s2.acc && data_s2.ready;
		r.trim_left         = (data_s2.acc && data_s2.tl_hit)
			? tswc_pkg::sat16(data_s2.tl_val) : '0;
		r.trim_right        = (data_s2.acc && data_s2.tr_hit)
			? tswc_pkg::sat16(data_s2.tr_val) : '0;
		r.ack_acceptable    = data_s2.ack_acc;
		r.ack_duplicate     = data_s2.dup;
		r.new_window_update = data_s2.acc && data_s2.nwu;
		r.syn_acked         = data_s2.syn;
		r.seg_fully_acked   = data_s2.fully;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			data_s3 <= r;
		end
	end

	`ASSERT_SAME(a_trim_gated, valid_s3 && !data_s3.seg_acceptable,
		data_s3.trim_left == '0 && data_s3.trim_right == '0, "trim on unacceptable segment")
	`ASSERT_SAME(a_ready_gated, valid_s3 && data_s3.seg_ready,
		data_s3.seg_acceptable, "ready on unacceptable segment")
	`ASSERT_SAME(a_nwu_gated, valid_s3 && data_s3.new_window_update,
		data_s3.seg_acceptable, "window update on unacceptable segment")
	`ASSERT_NEXT(a_hold_result, valid_s3 && !en, valid_s3 && $stable(data_s3),
		"stalled result changed")
endmodule

`default_nettype wire

### src/tcp_segment_window_check.sv
// Top level of the TCP segment window check pipeline
// A segment passes the stage 1, stage 2 and stage 3 registers in turn before its result is valid.
// Throughput: one segment per cycle; a stalled result holds stage 3, and a full stage holds
// while the stage after it holds.
// Each stage advances when it is empty or the stage after it advances.
// Reset clears the stage valid bits; data registers are not reset.
`default_nettype none
`include "assert_macros.svh"

module tcp_segment_window_check (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tswc_seg_if.sink     seg,
	tswc_res_if.source   result
);
	tswc_pkg::s1_t  data_s1;
	tswc_pkg::s2_t  data_s2;
	tswc_pkg::res_t data_s3;
	logic valid_s1, valid_s2, valid_s3;
	logic en1, en2, en3;

	assign en3 = !valid_s3 || result.ready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign seg.ready = en1;

	tswc_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en1),
		.seg      (seg),
		.data_s1  (data_s1),
		.valid_s1 (valid_s1)
	);

	tswc_cmp u_cmp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.data_s2  (data_s2),
		.valid_s2 (valid_s2)
	);

	tswc_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en3),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.data_s3  (data_s3),
		.valid_s3 (valid_s3)
	);

	assign result.valid             = valid_s3;
	assign result.seg_acceptable    = data_s3.seg_acceptable;
	assign result.seg_ready         = data_s3.seg_ready;
	assign result.trim_left         = data_s3.trim_left;
	assign result.trim_right        = data_s3.trim_right;
	assign result.ack_acceptable    = data_s3.ack_acceptable;
	assign result.ack_duplicate     = data_s3.ack_duplicate;
	assign result.new_window_update = data_s3.new_window_update;
	assign result.syn_acked         = data_s3.syn_acked;
	assign result.seg_fully_acked   = data_s3.seg_fully_acked;

	`ASSERT_NEXT(a_s1_moves, valid_s1 && en2, valid_s2, "stage 1 transfer lost")
	`ASSERT_NEXT(a_s2_moves, valid_s2 && en3, valid_s3, "stage 2 transfer lost")
	`ASSERT_SAME(a_full_stall, valid_s1 && valid_s2 && valid_s3 && !result.ready,
		!seg.ready, "input taken while pipeline is full and stalled")
endmodule

`default_nettype wire
